@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define ASSERT_AT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cnv_pkg.sv @@
package cnv_pkg;

  // Frame geometry and coefficient format.
  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int COEFF_FRAC_BITS = 8;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Pixel and arithmetic widths.
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int TAP_W  = 16;
  localparam int PROD_W = TAP_W + CH_W;
  localparam int SUM_W  = PROD_W + 4;

  // Register file.
  localparam int WIDTH_REG_W = 11;
  localparam int COEFF_REG_W = 3 * TAP_W;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 5;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_TOP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_MID   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_BOT   = 2'd3;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET     = 11'd640;
  localparam logic [COEFF_REG_W-1:0] COEFF_MID_RESET = 48'd256;

  // Coefficient rows, index 0 is the top row.
  typedef logic [2:0][COEFF_REG_W-1:0] coeff_set_t;

  // Completed 3x3 window handed from the line buffer to the lanes.
  typedef struct packed {
    logic                             valid;
    logic [ROW_W-1:0]                 row;
    logic [COL_W-1:0]                 col;
    logic [2:0][2:0][PIX_W-1:0]       pix;
  } win_t;

  // Row counter step, wrapping after the last supported row.
  function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] n;
    if (r == ROW_W'(MAX_HEIGHT - 1)) begin
      n = '0;
    end else begin
      n = r + ROW_W'(1);
    end
    return n;
  endfunction

endpackage

@@ design/cnv_if.sv @@
// Pixel request into the filter.
interface cnv_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [cnv_pkg::CH_W-1:0]  red_in;
  logic [cnv_pkg::CH_W-1:0]  green_in;
  logic [cnv_pkg::CH_W-1:0]  blue_in;
  logic                      frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

// Filtered pixel request out of the filter.
interface cnv_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [cnv_pkg::CH_W-1:0]   red_out;
  logic [cnv_pkg::CH_W-1:0]   green_out;
  logic [cnv_pkg::CH_W-1:0]   blue_out;
  logic [cnv_pkg::ROW_W-1:0]  centre_row;
  logic [cnv_pkg::COL_W-1:0]  centre_col;

  modport source (output valid, red_out, green_out, blue_out, centre_row, centre_col,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, centre_row, centre_col,
                  output ready);
endinterface

@@ design/cnv_ram.sv @@
module cnv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/cnv_window.sv @@
module cnv_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                take,
  input  logic [cnv_pkg::PIX_W-1:0]           cur_pix,
  input  logic                                frame_start,
  input  logic [cnv_pkg::WIDTH_REG_W-1:0]     image_width,
  output cnv_pkg::win_t                       win
);

  localparam int COL_W = cnv_pkg::COL_W;
  localparam int ROW_W = cnv_pkg::ROW_W;
  localparam int PIX_W = cnv_pkg::PIX_W;
  localparam int WRW   = cnv_pkg::WIDTH_REG_W;

  logic [WRW-1:0]     width_act;
  logic [COL_W-1:0]   col_cnt, col_cnt_next, col_a;
  logic [ROW_W-1:0]   row_cnt, row_cnt_next, row_a;
  logic [COL_W:0]     col_inc;
  logic               emit;

  logic               s1_valid;
  logic               s1_emit;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_crow;
  logic [COL_W-1:0]   s1_ccol;
  logic [PIX_W-1:0]   s1_cur;
  logic               s1_hit;
  logic [2*PIX_W-1:0] s1_byp;

  logic [2*PIX_W-1:0] line_rd;
  logic [2*PIX_W-1:0] line_eff;
  logic [PIX_W-1:0]   older_eff, newer_eff;

  logic [2:0][1:0][PIX_W-1:0] win_reg;

  logic                       win_valid;
  logic [ROW_W-1:0]           win_row;
  logic [COL_W-1:0]           win_col;
  logic [2:0][2:0][PIX_W-1:0] win_pix;

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    width_act = image_width;
    if (image_width < WRW'(3)) begin
      width_act = WRW'(3);
    end else if (image_width > WRW'(cnv_pkg::MAX_WIDTH)) begin
      width_act = WRW'(cnv_pkg::MAX_WIDTH);
    end
    col_a = frame_start ? '0 : col_cnt;
    row_a = frame_start ? '0 : row_cnt;
    // A width shrunk within a line restarts the column on a new row.
    if (WRW'(col_a) >= width_act) begin
      col_a = '0;
      row_a = cnv_pkg::next_row(row_a);
    end
    col_inc      = {1'b0, col_a} + (COL_W + 1)'(1);
    col_cnt_next = col_inc[COL_W-1:0];
    row_cnt_next = row_a;
    if (WRW'(col_inc) >= width_act) begin
      col_cnt_next = '0;
      row_cnt_next = cnv_pkg::next_row(row_a);
    end
    emit = (row_a >= ROW_W'(2)) && (col_a >= COL_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (take) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // Line stores: older row in the upper half, newer row in the lower half.
  cnv_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (cnv_pkg::MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (adv && s1_valid),
    .wr_addr (s1_col),
    .wr_data ({newer_eff, s1_cur}),
    .rd_en   (take),
    .rd_addr (col_a),
    .rd_data (line_rd)
  );

  // The previous pixel may write the column being read in the same cycle;
  // its data is then taken from the bypass register.
  assign line_eff  = s1_hit ? s1_byp : line_rd;
  assign older_eff = line_eff[2*PIX_W-1:PIX_W];
  assign newer_eff = line_eff[PIX_W-1:0];

  // Stage one: pixel waiting for its line store data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col  <= col_a;
      s1_emit <= emit;
      s1_crow <= row_a - ROW_W'(1);
      s1_ccol <= col_a - COL_W'(1);
      s1_cur  <= cur_pix;
      s1_hit  <= s1_valid && (s1_col == col_a);
      s1_byp  <= {newer_eff, s1_cur};
    end
  end

  // Left and middle columns of the window move along as each pixel leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= '0;
    end else if (adv && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_reg[r][0] <= win_reg[r][1];
      end
      win_reg[0][1] <= older_eff;
      win_reg[1][1] <= newer_eff;
      win_reg[2][1] <= s1_cur;
    end
  end

  // Stage two: the complete window for an interior centre.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (adv) begin
      win_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_row <= s1_crow;
      win_col <= s1_ccol;
      for (int r = 0; r < 3; r++) begin
        win_pix[r][0] <= win_reg[r][0];
        win_pix[r][1] <= win_reg[r][1];
      end
      win_pix[0][2] <= older_eff;
      win_pix[1][2] <= newer_eff;
      win_pix[2][2] <= s1_cur;
    end
  end

  always_comb begin
    win.valid = win_valid;
    win.row   = win_row;
    win.col   = win_col;
    win.pix   = win_pix;
  end

endmodule

@@ design/cnv_lane.sv @@
module cnv_lane (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [2:0][2:0][cnv_pkg::CH_W-1:0]   px,
  input  cnv_pkg::coeff_set_t                  coeff,
  output logic [cnv_pkg::CH_W-1:0]             result
);

  localparam int CH_W   = cnv_pkg::CH_W;
  localparam int TAP_W  = cnv_pkg::TAP_W;
  localparam int PROD_W = cnv_pkg::PROD_W;
  localparam int SUM_W  = cnv_pkg::SUM_W;
  localparam logic signed [SUM_W-1:0] CH_MAX = SUM_W'((1 << CH_W) - 1);

  logic signed [PROD_W-1:0] tap_x [3][3];
  logic signed [PROD_W-1:0] px_x  [3][3];
  logic signed [PROD_W-1:0] prod  [3][3];
  logic signed [SUM_W-1:0]  prod_x [3][3];
  logic signed [SUM_W-1:0]  row_sum [3];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  scaled;

  // Operands widened to the product width, taps sign extended.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        tap_x[r][k]  = PROD_W'($signed(coeff[r][TAP_W*k +: TAP_W]));
        px_x[r][k]   = PROD_W'({1'b0, px[r][k]});
        prod_x[r][k] = SUM_W'(prod[r][k]);
      end
    end
  end

  // Nine multipliers, registered.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= tap_x[r][k] * px_x[r][k];
        end
      end
    end
  end

  // Row sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] <= prod_x[r][0] + prod_x[r][1] + prod_x[r][2];
      end
    end
  end

  // Final sum, scaling and saturation to the channel range.
  assign total  = row_sum[0] + row_sum[1] + row_sum[2];
  assign scaled = total >>> cnv_pkg::COEFF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (total <= SUM_W'(0)) begin
        result <= '0;
      end else if (scaled > CH_MAX) begin
        result <= '1;
      end else begin
        result <= scaled[CH_W-1:0];
      end
    end
  end

endmodule

@@ design/rgb_convolution_3x3.sv @@
// 3x3 convolution over an RGB pixel stream in raster order. Each colour is
// filtered by its own lane with the nine signed Q8.8 taps of the three
// coefficient registers, shifted right by eight and clipped to 0..255.
// One pixel is taken in every clock cycle; the line store memory, with
// one read and one write each cycle, sets that figure. A result passes
// stages one and two, the lane registers and the output register; only
// interior centres give one, so border pixels produce nothing. A stalled
// output holds the whole pipeline and lowers ready on the input. The line
// stores are not cleared after reset; frame_start resets the position.
`include "assert_macros.svh"

module rgb_convolution_3x3 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cnv_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [cnv_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [cnv_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  cnv_pix_in_if.sink                          pixel_in,
  cnv_pix_out_if.source                       pixel_out
);

  localparam int CH_W  = cnv_pkg::CH_W;
  localparam int ROW_W = cnv_pkg::ROW_W;
  localparam int COL_W = cnv_pkg::COL_W;

  logic [cnv_pkg::WIDTH_REG_W-1:0] image_width;
  logic [cnv_pkg::COEFF_REG_W-1:0] coeff_top, coeff_mid, coeff_bot;
  logic [cnv_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            cfg_wr;

  logic                            adv;
  logic                            take;
  cnv_pkg::win_t                   win;
  cnv_pkg::coeff_set_t             coeff;

  logic [2:0][2:0][2:0][CH_W-1:0]  lane_px;
  logic [2:0][CH_W-1:0]            lane_res;

  logic [2:0]                      vld;
  logic [2:0][ROW_W-1:0]           row_d;
  logic [2:0][COL_W-1:0]           col_d;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[cnv_pkg::APB_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= cnv_pkg::WIDTH_RESET;
      coeff_top   <= '0;
      coeff_mid   <= cnv_pkg::COEFF_MID_RESET;
      coeff_bot   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        cnv_pkg::REG_IMAGE_WIDTH: image_width <= pwdata[cnv_pkg::WIDTH_REG_W-1:0];
        cnv_pkg::REG_COEFF_TOP:   coeff_top   <= pwdata[cnv_pkg::COEFF_REG_W-1:0];
        cnv_pkg::REG_COEFF_MID:   coeff_mid   <= pwdata[cnv_pkg::COEFF_REG_W-1:0];
        cnv_pkg::REG_COEFF_BOT:   coeff_bot   <= pwdata[cnv_pkg::COEFF_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cnv_pkg::REG_IMAGE_WIDTH: prdata = cnv_pkg::APB_DATA_W'(image_width);
      cnv_pkg::REG_COEFF_TOP:   prdata = cnv_pkg::APB_DATA_W'(coeff_top);
      cnv_pkg::REG_COEFF_MID:   prdata = cnv_pkg::APB_DATA_W'(coeff_mid);
      cnv_pkg::REG_COEFF_BOT:   prdata = cnv_pkg::APB_DATA_W'(coeff_bot);
      default:                  prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is free or being read.
  assign adv            = !vld[2] || pixel_out.ready;
  assign take           = pixel_in.valid && adv;
  assign pixel_in.ready = adv;

  cnv_window u_window (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .take        (take),
    .cur_pix     ({pixel_in.blue_in, pixel_in.green_in, pixel_in.red_in}),
    .frame_start (pixel_in.frame_start),
    .image_width (image_width),
    .win         (win)
  );

  // Split the window into one byte plane per colour lane.
  always_comb begin
    coeff = {coeff_bot, coeff_mid, coeff_top};
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          lane_px[c][r][k] = win.pix[r][k][CH_W*c +: CH_W];
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    cnv_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .px     (lane_px[c]),
      .coeff  (coeff),
      .result (lane_res[c])
    );
  end

  // Valid and centre position follow the lanes, the last stage being the
  // output register that merges the three colours.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], win.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_d <= {row_d[1:0], win.row};
      col_d <= {col_d[1:0], win.col};
    end
  end

  assign pixel_out.valid      = vld[2];
  assign pixel_out.red_out    = lane_res[0];
  assign pixel_out.green_out  = lane_res[1];
  assign pixel_out.blue_out   = lane_res[2];
  assign pixel_out.centre_row = row_d[2];
  assign pixel_out.centre_col = col_d[2];

  // Results belong to interior centres only.
  `ASSERT_AT_CLK(a_centre_interior, pixel_out.valid |-> (pixel_out.centre_row != '0 && pixel_out.centre_col != '0), "result for a border centre")
  // A result waiting at the output holds back the input side.
  `ASSERT_AT_CLK(a_stall_blocks_input, (pixel_out.valid && !pixel_out.ready) |-> !pixel_in.ready, "input taken while output stalled")
  // Reset leaves no window and no result pending.
  `ASSERT_NEXT(a_reset_idle, rst, !pixel_out.valid && !win.valid, "pipeline not empty after reset")

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W            = cnv_pkg::CH_W;
  localparam int PIX_W           = cnv_pkg::PIX_W;
  localparam int ROW_W           = cnv_pkg::ROW_W;
  localparam int COL_W           = cnv_pkg::COL_W;
  localparam int TAP_W           = cnv_pkg::TAP_W;
  localparam int COEFF_FRAC_BITS = cnv_pkg::COEFF_FRAC_BITS;
  localparam int MAX_WIDTH       = cnv_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT      = cnv_pkg::MAX_HEIGHT;
  localparam int APB_ADDR_W      = cnv_pkg::APB_ADDR_W;
  localparam int APB_DATA_W      = cnv_pkg::APB_DATA_W;
  localparam int WIDTH_REG_W     = cnv_pkg::WIDTH_REG_W;
  localparam int COEFF_REG_W     = cnv_pkg::COEFF_REG_W;
  localparam int REG_IDX_W       = cnv_pkg::REG_IDX_W;

  typedef logic [2:0][2:0][PIX_W-1:0] pix_window_t;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } filtered_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cnv_pix_in_if  pix_in_bus ();
  cnv_pix_out_if pix_out_bus ();

  rgb_convolution_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pixel_in  (pix_in_bus),
    .pixel_out (pix_out_bus)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idling controls shared by the sender, the receiver and the tests.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_off_left = 0;
  bit          flush_output  = 1'b0;
  int unsigned mismatches    = 0;

  // Predictor state: register copies, line history and raster position.
  logic [WIDTH_REG_W-1:0]    width_setting = cnv_pkg::WIDTH_RESET;
  logic [COEFF_REG_W-1:0]    coeff_setting [3];
  logic [PIX_W-1:0]          two_rows_up [MAX_WIDTH];
  logic [PIX_W-1:0]          one_row_up [MAX_WIDTH];
  logic [2:0][1:0][PIX_W-1:0] left_cols = '0;
  int unsigned               pos_col = 0;
  int unsigned               pos_row = 0;
  filtered_pixel_t           pending_filtered [$];

  initial begin
    coeff_setting[0] = '0;
    coeff_setting[1] = cnv_pkg::COEFF_MID_RESET;
    coeff_setting[2] = '0;
  end

  // Line length as the block uses it, with the register clamped to the legal range.
  function automatic int unsigned line_length();
    int unsigned len;
    len = width_setting;
    if (len < 3) len = 3;
    if (len > MAX_WIDTH) len = MAX_WIDTH;
    return len;
  endfunction

  // One colour of the 3x3 window against the nine signed taps, then shift and clip.
  function automatic logic [CH_W-1:0] convolve_channel(input pix_window_t win, input int ch);
    longint acc;
    longint tap;
    longint sample;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        tap    = longint'($signed(coeff_setting[r][TAP_W*k +: TAP_W]));
        sample = longint'(win[r][k][CH_W*ch +: CH_W]);
        acc    = acc + tap * sample;
      end
    end
    if (acc <= 0) return '0;
    acc = acc >>> COEFF_FRAC_BITS;
    if (acc > 255) return 8'hFF;
    return acc[CH_W-1:0];
  endfunction

  // Advances the predicted raster position by one pixel and queues any result it completes.
  task automatic convolve_pixel(input logic [CH_W-1:0] r, g, b, input logic fs);
    int unsigned     len;
    pix_window_t     win;
    filtered_pixel_t res;
    len = line_length();
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= len) begin
      pos_col = 0;
      pos_row = (pos_row + 1) % MAX_HEIGHT;
    end
    win[0][2] = two_rows_up[pos_col];
    win[1][2] = one_row_up[pos_col];
    win[2][2] = {b, g, r};
    two_rows_up[pos_col] = win[1][2];
    one_row_up[pos_col]  = win[2][2];
    for (int i = 0; i < 3; i++) begin
      win[i][0] = left_cols[i][0];
      win[i][1] = left_cols[i][1];
    end
    if (pos_row >= 2 && pos_col >= 2) begin
      res.red   = convolve_channel(win, 0);
      res.green = convolve_channel(win, 1);
      res.blue  = convolve_channel(win, 2);
      res.row   = ROW_W'(pos_row - 1);
      res.col   = COL_W'(pos_col - 1);
      pending_filtered.push_back(res);
    end
    for (int i = 0; i < 3; i++) begin
      left_cols[i][0] = win[i][1];
      left_cols[i][1] = win[i][2];
    end
    pos_col = pos_col + 1;
    if (pos_col >= len) begin
      pos_col = 0;
      pos_row = (pos_row + 1) % MAX_HEIGHT;
    end
  endtask

  // Every accepted pixel request is fed to the predictor.
  always @(posedge clk) begin
    if (!rst && pix_in_bus.valid && pix_in_bus.ready) begin
      convolve_pixel(pix_in_bus.red_in, pix_in_bus.green_in, pix_in_bus.blue_in,
                     pix_in_bus.frame_start);
    end
  end

  task automatic log_mismatch(input string what, input filtered_pixel_t want,
                              input filtered_pixel_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected rgb %02h %02h %02h at (%0d,%0d),",
               what, want.red, want.green, want.blue, want.row, want.col,
               " got rgb %02h %02h %02h at (%0d,%0d)",
               got.red, got.green, got.blue, got.row, got.col);
    end
  endtask

  // Each filtered pixel request is compared with the oldest prediction.
  always @(posedge clk) begin : check_filtered
    filtered_pixel_t got;
    filtered_pixel_t want;
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      got.red   = pix_out_bus.red_out;
      got.green = pix_out_bus.green_out;
      got.blue  = pix_out_bus.blue_out;
      got.row   = pix_out_bus.centre_row;
      got.col   = pix_out_bus.centre_col;
      if (pending_filtered.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_filtered.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.row !== want.row || got.col !== want.col) begin
          log_mismatch("wrong result", want, got);
        end
      end
    end
  end

  // Receiver: a counted hold-off first, then flushing, otherwise random stalls.
  initial begin
    pix_out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left != 0) begin
        hold_off_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (flush_output) begin
        pix_out_bus.ready <= 1'b1;
      end else begin
        pix_out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offers one pixel request, after random idle cycles, and waits until it is taken.
  task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_bus.valid       <= 1'b1;
    pix_in_bus.red_in      <= r;
    pix_in_bus.green_in    <= g;
    pix_in_bus.blue_in     <= b;
    pix_in_bus.frame_start <= fs;
    @(posedge clk);
    while (!pix_in_bus.ready) @(posedge clk);
  endtask

  // Stops the input, lets every outstanding result drain and then lets the bench idle.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    pix_in_bus.valid <= 1'b0;
    flush_output = 1'b1;
    while (pending_filtered.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    flush_output = 1'b0;
  endtask

  // APB write: setup cycle, access cycle, then the bus goes idle before the task returns.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cnv_pkg::REG_IMAGE_WIDTH: width_setting    = value[WIDTH_REG_W-1:0];
      cnv_pkg::REG_COEFF_TOP:   coeff_setting[0] = value[COEFF_REG_W-1:0];
      cnv_pkg::REG_COEFF_MID:   coeff_setting[1] = value[COEFF_REG_W-1:0];
      cnv_pkg::REG_COEFF_BOT:   coeff_setting[2] = value[COEFF_REG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly small taps so that sums land mid-range, with extremes and raw values mixed in.
  function automatic logic [APB_DATA_W-1:0] random_coeff_row();
    logic [COEFF_REG_W-1:0] row;
    logic [TAP_W-1:0]       tap;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0: tap = TAP_W'($urandom);
        1: tap = 16'h7FFF;
        2: tap = 16'h8000;
        3: tap = '0;
        default: begin
          tap = TAP_W'($urandom_range(0, 80));
          if ($urandom_range(0, 1) == 1) tap = -tap;
        end
      endcase
      row[TAP_W*k +: TAP_W] = tap;
    end
    return APB_DATA_W'(row);
  endfunction

  function automatic logic [APB_DATA_W-1:0] random_width();
    case ($urandom_range(0, 19))
      0:          return APB_DATA_W'($urandom_range(0, 2));
      1, 2, 3, 4: return APB_DATA_W'($urandom_range(11, 40));
      default:    return APB_DATA_W'($urandom_range(3, 10));
    endcase
  endfunction

  task automatic load_random_coeffs();
    write_register(cnv_pkg::REG_COEFF_TOP, random_coeff_row());
    write_register(cnv_pkg::REG_COEFF_MID, random_coeff_row());
    write_register(cnv_pkg::REG_COEFF_BOT, random_coeff_row());
  endtask

  // Centre tap of 1.0 on a frame of four short lines: the output is the centre pixel.
  task automatic test_identity_frame();
    write_register(cnv_pkg::REG_IMAGE_WIDTH, 64'd0);
    write_register(cnv_pkg::REG_COEFF_TOP, 64'd0);
    write_register(cnv_pkg::REG_COEFF_MID, 64'h0000_0100_0000);
    write_register(cnv_pkg::REG_COEFF_BOT, 64'd0);
    for (int i = 0; i < 12; i++) begin
      send_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hAA : 8'h55, 8'(i * 23), i == 0);
    end
    settle();
  endtask

  // Largest positive taps clip at the top, most negative taps clip at zero.
  task automatic test_saturation();
    write_register(cnv_pkg::REG_IMAGE_WIDTH, 64'd3);
    write_register(cnv_pkg::REG_COEFF_TOP, 64'h7FFF_7FFF_7FFF);
    write_register(cnv_pkg::REG_COEFF_MID, 64'h7FFF_7FFF_7FFF);
    write_register(cnv_pkg::REG_COEFF_BOT, 64'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
    settle();
    write_register(cnv_pkg::REG_COEFF_TOP, 64'h8000_8000_8000);
    write_register(cnv_pkg::REG_COEFF_MID, 64'h8000_8000_8000);
    write_register(cnv_pkg::REG_COEFF_BOT, 64'h8000_8000_8000);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
    settle();
  endtask

  // Width cut to exactly the current column in mid-line: the next pixel opens a new line.
  task automatic test_width_shrink();
    write_register(cnv_pkg::REG_IMAGE_WIDTH, 64'd8);
    load_random_coeffs();
    for (int i = 0; i < 21; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
    settle();
    write_register(cnv_pkg::REG_IMAGE_WIDTH, 64'd5);
    for (int i = 0; i < 15; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    settle();
  endtask

  // The receiver holds off for a long stretch while pixels keep coming.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_register(cnv_pkg::REG_IMAGE_WIDTH, 64'd6);
    hold_off_left = 400;
    for (int i = 0; i < 72; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
    settle();
  endtask

  // Well-formed frames of random size and content, some cut short, some run on.
  task automatic test_random_frames(input int unsigned item_goal);
    int unsigned sent;
    int unsigned old_len;
    int unsigned total;
    logic        fs;
    sent = 0;
    while (sent < item_goal) begin
      old_len = line_length();
      if ($urandom_range(0, 2) == 0) begin
        settle();
        if ($urandom_range(0, 1) == 1) begin
          write_register(cnv_pkg::REG_IMAGE_WIDTH, random_width());
        end
        if ($urandom_range(0, 1) == 1) begin
          write_register(cnv_pkg::REG_COEFF_TOP, random_coeff_row());
        end
        if ($urandom_range(0, 1) == 1) begin
          write_register(cnv_pkg::REG_COEFF_MID, random_coeff_row());
        end
        if ($urandom_range(0, 1) == 1) begin
          write_register(cnv_pkg::REG_COEFF_BOT, random_coeff_row());
        end
      end
      total = line_length() * $urandom_range(3, 7);
      if ($urandom_range(0, 5) == 0) total = $urandom_range(1, total);
      for (int i = 0; i < total; i++) begin
        // A wider line is only safe at the start of a new frame.
        fs = (i == 0) && (line_length() > old_len || $urandom_range(0, 7) != 0);
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), fs);
      end
      sent = sent + total;
    end
  endtask

  initial begin
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    pix_in_bus.valid       = 1'b0;
    pix_in_bus.red_in      = '0;
    pix_in_bus.green_in    = '0;
    pix_in_bus.blue_in     = '0;
    pix_in_bus.frame_start = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_identity_frame();
    test_saturation();
    test_width_shrink();
    test_back_pressure();

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_frames(180);
    send_idle_pct = 59;
    stall_pct     = 0;
    test_random_frames(180);
    send_idle_pct = 0;
    stall_pct     = 59;
    test_random_frames(180);
    send_idle_pct = 12;
    stall_pct     = 12;
    test_random_frames(180);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_filtered.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_filtered.size() != 0) begin
        $display("%0d predicted results never arrived", pending_filtered.size());
      end
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule
